// File: hw/rtl/ibg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the indexed bitmap to grayscale block
package ibg_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int PALETTE_DEPTH = 256;

  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int RGB_W    = 3 * COLOR_W;
  localparam int CNT_W    = 11;
  localparam int ADDR_W   = 20;
  localparam int WREG_W   = 11;
  localparam int HREG_W   = 12;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = COLOR_W + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // q16 luma weights
  localparam logic [WEIGHT_W-1:0] WEIGHT_R = 16'd19588;
  localparam logic [WEIGHT_W-1:0] WEIGHT_G = 16'd38470;
  localparam logic [WEIGHT_W-1:0] WEIGHT_B = 16'd7471;

  typedef enum logic [0:0] {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // image geometry after clamping the raw registers
  typedef struct packed {
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] width_last;
    logic [CNT_W-1:0] pad_last;
    logic [CNT_W-1:0] rows_last;
    logic             top_down;
  } geom_t;

  // position of one pixel on its way to the output
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] disp_row;
    logic             last;
  } tag_t;

endpackage

// File: hw/rtl/ibg_feed_if.sv
`timescale 1ns / 1ps
// input channel: palette writes and raw pixel bytes
interface ibg_feed_if;
  logic                           valid;
  logic                           ready;
  logic [0:0]                     op;
  logic [ibg_pkg::INDEX_W-1:0]    palette_slot;
  logic [ibg_pkg::COLOR_W-1:0]    red;
  logic [ibg_pkg::COLOR_W-1:0]    green;
  logic [ibg_pkg::COLOR_W-1:0]    blue;
  logic [ibg_pkg::INDEX_W-1:0]    pixel_byte;

  modport source (output valid, op, palette_slot, red, green, blue, pixel_byte,
                  input ready);
  modport sink (input valid, op, palette_slot, red, green, blue, pixel_byte,
                output ready);
endinterface

// File: hw/rtl/ibg_result_if.sv
`timescale 1ns / 1ps
// output channel: gray pixels with their destination address
interface ibg_result_if;
  logic                         valid;
  logic                         ready;
  logic [ibg_pkg::COLOR_W-1:0]  gray;
  logic [ibg_pkg::ADDR_W-1:0]   pixel_address;
  logic                         last;

  modport source (output valid, gray, pixel_address, last, input ready);
  modport sink (input valid, gray, pixel_address, last, output ready);
endinterface

// File: hw/rtl/ibg_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module ibg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ibg_cfg.sv
`timescale 1ns / 1ps
// apb register file for image width and height, with clamped geometry
module ibg_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ibg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ibg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ibg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic                            restart,
  output ibg_pkg::geom_t                  geom
);
  import ibg_pkg::*;

  logic [WREG_W-1:0] image_width;
  logic [HREG_W-1:0] image_height;
  logic              wr;
  reg_idx_t          idx;
  logic [CNT_W-1:0]  w_eff;
  logic [HREG_W-1:0] h_mag;
  logic [CNT_W-1:0]  rows_eff;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign idx     = reg_idx_t'(paddr[2]);
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WREG_W'(1);
      image_height <= HREG_W'(1);
    end else if (wr) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WREG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // clamp width to 1..MAX_WIDTH
  always_comb begin
    priority if (image_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (image_width > WREG_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(image_width);
    end
  end

  // height: sign gives storage order, magnitude clamped to 1..MAX_HEIGHT
  always_comb begin
    h_mag = image_height[HREG_W-1] ? (~image_height + HREG_W'(1)) : image_height;
    priority if (h_mag == '0) begin
      rows_eff = CNT_W'(1);
    end else if (h_mag > HREG_W'(MAX_HEIGHT)) begin
      rows_eff = CNT_W'(MAX_HEIGHT);
    end else begin
      rows_eff = h_mag[CNT_W-1:0];
    end
  end

  always_comb begin
    geom.width      = w_eff;
    geom.width_last = w_eff - CNT_W'(1);
    // last byte of a row padded to four bytes
    geom.pad_last   = (w_eff - CNT_W'(1)) | CNT_W'(3);
    geom.rows_last  = rows_eff - CNT_W'(1);
    geom.top_down   = image_height[HREG_W-1];
  end

endmodule

// File: hw/rtl/ibg_walk.sv
`timescale 1ns / 1ps
// column and row counters over the stored byte stream
module ibg_walk (
  input  logic            clk,
  input  logic            rst,
  input  logic            restart,
  input  logic            step,
  input  ibg_pkg::geom_t  geom,
  output logic            emit,
  output ibg_pkg::tag_t   tag
);
  import ibg_pkg::*;

  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col_next;
  logic [CNT_W-1:0] row_next;

  always_comb begin
    col_next = col + CNT_W'(1);
    row_next = row;
    if (col >= geom.pad_last) begin
      col_next = '0;
      row_next = (row >= geom.rows_last) ? '0 : row + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // padding bytes fall outside the visible width
  assign emit         = (col <= geom.width_last) && (row <= geom.rows_last);
  assign tag.col      = col;
  assign tag.disp_row = geom.top_down ? row : (geom.rows_last - row);
  assign tag.last     = (col == geom.width_last) && (row == geom.rows_last);

endmodule

// File: hw/rtl/ibg_luma.sv
`timescale 1ns / 1ps
// two-stage weighted sum of the palette color
module ibg_luma (
  input  logic                          clk,
  input  logic                          en_mul,
  input  logic                          en_sum,
  input  logic [ibg_pkg::RGB_W-1:0]     rgb,
  output logic [ibg_pkg::COLOR_W-1:0]   gray
);
  import ibg_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r <= rgb[RGB_W-1 -: COLOR_W] * WEIGHT_R;
      prod_g <= rgb[COLOR_W +: COLOR_W] * WEIGHT_G;
      prod_b <= rgb[COLOR_W-1:0] * WEIGHT_B;
    end
  end

  assign sum = SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b);

  // drop the sixteen fraction bits
  always_ff @(posedge clk) begin
    if (en_sum) begin
      gray <= sum[WEIGHT_W +: COLOR_W];
    end
  end

endmodule

// File: hw/rtl/indexed_bitmap_to_grayscale.sv
`timescale 1ns / 1ps
// Converts palette-indexed bitmap bytes to 8-bit gray at one item per clock
// while the output is not stalled. Palette writes go to the write port of a
// 256x24 ram and pixel bytes look up the color on its read port in the same
// cycle they are taken; a lookup right after a write to the same slot sees the
// new color, so no interlock is needed. A gray result passes the ram read,
// multiply and sum registers after its byte is taken, and each stage moves on
// whenever the stage after it is empty or moving, so bubbles from palette
// writes and padding bytes close up under output stalls. The palette has no
// clearing pass: entries read before being written give undefined gray.
// Writing either register restarts the image at its first stored byte.
module indexed_bitmap_to_grayscale (
  input  logic                            clk,
  input  logic                            rst,
  ibg_feed_if.sink                        feed,
  ibg_result_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ibg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ibg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ibg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ibg_pkg::*;

  geom_t             geom;
  logic              restart;
  logic              emit;
  tag_t              tag;
  logic              adv1;
  logic              adv2;
  logic              adv3;
  logic              fire;
  logic              pix_step;
  logic              pal_wr;
  logic              v1;
  logic              v2;
  logic              v3;
  tag_t              tag1;
  logic [ADDR_W-1:0] addr2;
  logic              last2;
  logic [ADDR_W-1:0] addr3;
  logic              last3;
  logic [RGB_W-1:0]  rgb;
  logic [2*CNT_W-1:0] row_base;

  ibg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .restart (restart),
    .geom    (geom)
  );

  // each stage loads when the next one is empty or handing on
  assign adv3 = !v3 || result.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign feed.ready = adv1;
  assign fire       = feed.valid && adv1;
  assign pix_step   = fire && (op_t'(feed.op) == OP_PIXEL);
  assign pal_wr     = fire && (op_t'(feed.op) == OP_PALETTE);

  ibg_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .step    (pix_step),
    .geom    (geom),
    .emit    (emit),
    .tag     (tag)
  );

  ibg_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_wr),
    .waddr (feed.palette_slot),
    .wdata ({feed.red, feed.green, feed.blue}),
    .re    (adv1),
    .raddr (feed.pixel_byte),
    .rdata (rgb)
  );

  ibg_luma u_luma (
    .clk    (clk),
    .en_mul (adv2),
    .en_sum (adv3),
    .rgb    (rgb),
    .gray   (result.gray)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= pix_step && emit;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  assign row_base = tag1.disp_row * geom.width;

  always_ff @(posedge clk) begin
    if (adv1) begin
      tag1 <= tag;
    end
    if (adv2) begin
      addr2 <= row_base[ADDR_W-1:0] + ADDR_W'(tag1.col);
      last2 <= tag1.last;
    end
    if (adv3) begin
      addr3 <= addr2;
      last3 <= last2;
    end
  end

  assign result.valid         = v3;
  assign result.pixel_address = addr3;
  assign result.last          = last3;

endmodule

// File: hw/rtl/ibg_check.sv
`timescale 1ns / 1ps
// port-level checks of the grayscale block, bound to the top level
module ibg_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            feed_ready,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  logic [ibg_pkg::COLOR_W-1:0]     gray,
  input  logic [ibg_pkg::ADDR_W-1:0]      pixel_address,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ibg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ibg_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic [ibg_pkg::APB_DATA_W-1:0]  prdata
);
  import ibg_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite && pready;

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty or draining output register must never block the input
  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || result_ready) |-> feed_ready)
    else $error("input stalled while output is free");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(gray) && $stable(pixel_address)))
    else $error("stalled result changed");

  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    (wr && !paddr[2]) ##1 !paddr[2] |->
      prdata[WREG_W-1:0] == $past(pwdata[WREG_W-1:0]))
    else $error("width register readback mismatch");

endmodule

bind indexed_bitmap_to_grayscale ibg_check u_ibg_check (
  .clk           (clk),
  .rst           (rst),
  .feed_ready    (feed.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .gray          (result.gray),
  .pixel_address (result.pixel_address),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pready        (pready),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
